### rtl/core/hopf_pkg.sv
// ----------------------------------------------------------------------------
// Hamming one-pair finder package
// Shared item types, register indexes, opcodes and default sizes.
// ----------------------------------------------------------------------------
package hopf_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_SITE_COUNT  = 16;
    localparam int WORD_BITS       = 16;
    localparam int RESULT_CAP      = 32;
    localparam int CMD_DEPTH       = 2;
    localparam int RES_DEPTH       = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_SITES   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  slot;
        logic [15:0] haplotype_bits;
    } in_item_t;

    typedef struct packed {
        logic [4:0] first_index;
        logic [4:0] second_index;
        logic       found;
        logic       last;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic        is_query;
        logic        slot_ok;
        logic [4:0]  slot;
        logic [15:0] word;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

### rtl/core/hopf_fifo.sv
// ----------------------------------------------------------------------------
// Hamming one-pair finder queue
// Small first-in first-out register queue with push/pop and full/empty.
// ----------------------------------------------------------------------------
module hopf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/hopf_front.sv
// ----------------------------------------------------------------------------
// Hamming one-pair finder front
// Accepts input beats, decodes the opcode, range-checks the slot and queues
// the classified command for the back.
// ----------------------------------------------------------------------------
module hopf_front #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hopf_pkg::in_item_t item,
    output logic            full,
    input  logic            cmd_pop,
    output hopf_pkg::cmd_t  cmd,
    output logic            cmd_empty
);
    import hopf_pkg::*;

    cmd_t cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_raw;

    always_comb
    begin
        cmd_in.is_query = (item.opcode == OP_QUERY);
        cmd_in.slot_ok  = ({2'b00, item.slot} < 7'(TABLE_DEPTH));
        cmd_in.slot     = item.slot;
        cmd_in.word     = item.haplotype_bits;
    end

    hopf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_raw),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_raw);

endmodule

### rtl/core/hopf_back.sv
// ----------------------------------------------------------------------------
// Hamming one-pair finder back
// Holds the haplotype table, performs loads and scans it for queries, one slot
// compare per cycle unless the result queue it pushes beats to is full.
// ----------------------------------------------------------------------------
module hopf_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hopf_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    input  logic [5:0]         scan_len,
    input  logic [15:0]        site_mask,
    input  logic               res_full,
    output logic               res_push,
    output hopf_pkg::out_item_t res
);
    import hopf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0]   mem [TABLE_DEPTH];
    logic [15:0]   rdata_reg;

    back_state_t   state_reg, state_next;
    logic [5:0]    j_reg, j_next;
    logic [4:0]    qslot_reg, qslot_next;
    logic [15:0]   base_reg, base_next;
    logic [4:0]    pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;

    logic [5:0]    rd_idx;
    logic [6:0]    rd_wide;
    logic [6:0]    wr_wide;
    logic          mem_we;
    logic [15:0]   diff;
    logic          hit;
    logic          advance;

    assign rd_wide = {1'b0, rd_idx};
    assign wr_wide = {2'b00, cmd.slot};
    assign diff    = (base_reg ^ rdata_reg) & site_mask;
    // Exactly one differing site.
    assign hit     = (diff != '0) && ((diff & (diff - 16'd1)) == '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_wide[AW-1:0]] <= cmd.word;
        end
        rdata_reg <= mem[rd_wide[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        qslot_reg <= qslot_next;
        base_reg  <= base_next;
        pend_reg  <= pend_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        qslot_next      = qslot_reg;
        base_next       = base_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        rd_idx          = j_reg;
        res_push        = 1'b0;
        advance         = 1'b0;
        res.first_index  = qslot_reg;
        res.second_index = pend_reg;
        res.found        = 1'b1;
        res.last         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx = {1'b0, cmd.slot};
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_query)
                    begin
                        mem_we = cmd.slot_ok;
                    end
                    else
                    begin
                        qslot_next      = cmd.slot;
                        pend_valid_next = 1'b0;
                        if (cmd.slot_ok && (scan_len != '0))
                        begin
                            state_next = ST_BASE;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_BASE:
            begin
                // The queried word arrives now; start reading slot zero.
                base_next  = rdata_reg;
                rd_idx     = '0;
                j_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // A hit is held back until the next hit or the finish so the final one can be marked last.
                advance = !(hit && pend_valid_reg && res_full);
                if (hit && pend_valid_reg && !res_full)
                begin
                    res_push = 1'b1;
                end
                if (hit && advance)
                begin
                    pend_next       = j_reg[4:0];
                    pend_valid_next = 1'b1;
                end
                if (advance)
                begin
                    if (j_reg == scan_len - 6'd1)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        j_next = j_reg + 6'd1;
                        rd_idx = j_reg + 6'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                res.second_index = pend_valid_reg ? pend_reg : 5'd0;
                res.found        = pend_valid_reg;
                res.last         = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/hamming_one_pair_finder_top.sv
// ----------------------------------------------------------------------------
// Hamming one-pair finder
// Finds every scanned table slot whose haplotype differs from a queried slot
// in exactly one active site.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are written with push while full is low. A load beat writes
//   one haplotype word into a slot; a query beat names a slot to scan for.
//   Result beats are read with pop while empty is low; each carries a pair,
//   and the final beat of a query has last set. A query with no neighbor
//   gives a single beat with found low and last set.
//   A load is written as the back takes it. A query takes the command, reads
//   the queried word, compares the scanned slots one at a time through the
//   single table read port, and ends with the closing beat; with nothing to
//   scan, or a slot past the table, it goes straight to the closing beat.
//   Registers entries_in_use and sites_in_use are written through cfg_we,
//   cfg_addr and cfg_data; the user must write them only while the block is
//   idle, which the block itself does not enforce. Reset empties both queues
//   and returns the registers to 32 and 16; the table contents are undefined
//   until loaded. When the receiver stalls, the result queue fills and the
//   scan pauses at the next beat it must push; input beats keep being taken
//   until the command queue is full.
// ----------------------------------------------------------------------------
module hamming_one_pair_finder_top #(
    parameter int TABLE_DEPTH = hopf_pkg::DEF_TABLE_DEPTH,
    parameter int SITE_COUNT  = hopf_pkg::DEF_SITE_COUNT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hopf_pkg::in_item_t  item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output hopf_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [5:0]          cfg_data
);
    import hopf_pkg::*;

    localparam int SCAN_LIM = (TABLE_DEPTH < RESULT_CAP) ? TABLE_DEPTH : RESULT_CAP;
    localparam int SITE_LIM = (SITE_COUNT < WORD_BITS) ? SITE_COUNT : WORD_BITS;

    logic [5:0]  entries_reg;
    logic [4:0]  sites_reg;
    logic [5:0]  scan_len;
    logic [4:0]  site_sat;
    logic [16:0] mask_wide;
    logic [15:0] site_mask;

    cmd_t        cmd;
    logic        cmd_empty;
    logic        cmd_pop;
    logic        res_full;
    logic        res_push;
    out_item_t   res;
    logic [$bits(out_item_t)-1:0] res_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= 6'd32;
            sites_reg   <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENTRIES: entries_reg <= cfg_data;
                REG_SITES:   sites_reg   <= cfg_data[4:0];
                default:     entries_reg <= entries_reg;
            endcase
        end
    end

    assign scan_len  = (entries_reg > 6'(SCAN_LIM)) ? 6'(SCAN_LIM) : entries_reg;
    assign site_sat  = (sites_reg > 5'(SITE_LIM)) ? 5'(SITE_LIM) : sites_reg;
    assign mask_wide = (17'd1 << site_sat) - 17'd1;
    assign site_mask = mask_wide[15:0];

    hopf_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    hopf_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .scan_len  (scan_len),
        .site_mask (site_mask),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    hopf_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_raw),
        .empty (empty)
    );

    assign result = out_item_t'(res_raw);

endmodule
